// ----- design/lcdseq_pkg.sv -----
// Shared types, codes and constants of the character LCD bus sequencer.
// No dependencies; every other design file imports this package.
package lcdseq_pkg;

    // Request function codes.
    localparam logic [2:0] FUNC_CMD     = 3'd0;
    localparam logic [2:0] FUNC_DATA    = 3'd1;
    localparam logic [2:0] FUNC_CURSOR  = 3'd2;
    localparam logic [2:0] FUNC_DATA_AT = 3'd3;
    localparam logic [2:0] FUNC_POWER   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FOUR_BIT = 2'd0;
    localparam logic [1:0] CFG_EN_US    = 2'd1;
    localparam logic [1:0] CFG_WAIT_US  = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  EN_US_RESET   = 8'd5;
    localparam logic [15:0] WAIT_US_RESET = 16'd20000;

    // DDRAM base addresses of rows one to four.
    localparam logic [7:0] ROW1_BASE = 8'h80;
    localparam logic [7:0] ROW2_BASE = 8'hC0;
    localparam logic [7:0] ROW3_BASE = 8'h94;
    localparam logic [7:0] ROW4_BASE = 8'hD4;

    // Power-up sequence: step 0 is the initial wait, steps 1 to 9 are commands.
    localparam logic [3:0]  INIT_LAST_STEP   = 4'd9;
    localparam logic [15:0] WAIT_FIRST_US    = 16'd5000;
    localparam logic [15:0] WAIT_SECOND_US   = 16'd150;
    localparam logic [7:0]  CMD_FUNC_SET_8   = 8'h38;
    localparam logic [7:0]  CMD_FUNC_SET_4   = 8'h28;
    localparam logic [7:0]  CMD_CLEAR        = 8'h01;
    localparam logic [7:0]  CMD_HOME         = 8'h02;
    localparam logic [7:0]  CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0]  CMD_DDRAM_START  = 8'h80;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic [2:0] row;
        logic [5:0] column;
    } t_req;

    typedef struct packed {
        logic        reg_select;
        logic [7:0]  data_lines;
        logic        enable_line;
        logic [15:0] hold_us;
        logic        last;
    } t_pin;

    // One job for the datapath: a byte transfer or a single idle pin state.
    typedef struct packed {
        logic        start;
        logic        idle_job;
        logic        rs;
        logic [7:0]  byte_val;
        logic [15:0] tail_hold;
        logic        last;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } t_state;

    function automatic logic [7:0] f_init_byte(input logic [3:0] step,
                                               input logic four_bit);
        logic [7:0] b;
        case (step)
            4'd1, 4'd2, 4'd3: b = CMD_FUNC_SET_8;
            4'd4:             b = CMD_CLEAR;
            4'd5:             b = CMD_HOME;
            4'd6:             b = CMD_ENTRY_MODE;
            4'd7:             b = CMD_DISPLAY_ON;
            4'd8:             b = four_bit ? CMD_FUNC_SET_4 : CMD_FUNC_SET_8;
            4'd9:             b = CMD_DDRAM_START;
            default:          b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] f_init_tail(input logic [3:0] step);
        logic [15:0] h;
        case (step)
            4'd1:    h = WAIT_FIRST_US;
            4'd2:    h = WAIT_SECOND_US;
            default: h = 16'd0;
        endcase
        return h;
    endfunction

endpackage

// ----- design/lcdseq_ctrl.sv -----
// Controller of the LCD bus sequencer: walks a request through its byte jobs.
// Depends on lcdseq_pkg; drives lcdseq_dp through a t_dp_cmd.
module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    input  logic        i_four_bit,
    input  logic [15:0] i_wait_us,
    input  logic        i_dp_busy,
    output t_dp_cmd     o_cmd
);

    t_state      r_state, n_state;
    t_req        r_req;
    logic [3:0]  r_step, n_step;

    logic        w_row_ok;
    logic [7:0]  w_base;
    logic [7:0]  w_addr;
    logic        w_has_job;
    logic        w_final;
    t_dp_cmd     w_job;

    always_comb begin
        w_row_ok = 1'b1;
        unique case (r_req.row)
            3'd1:    w_base = ROW1_BASE;
            3'd2:    w_base = ROW2_BASE;
            3'd3:    w_base = ROW3_BASE;
            3'd4:    w_base = ROW4_BASE;
            default: begin
                w_base   = 8'h00;
                w_row_ok = 1'b0;
            end
        endcase
    end

    // Row base plus column minus one, wrapping at 256.
    assign w_addr = w_base + {2'b00, r_req.column} + 8'hFF;

    // Job for the current step of the held request.
    always_comb begin
        w_has_job          = 1'b0;
        w_final            = 1'b1;
        w_job              = '0;
        w_job.tail_hold    = 16'd0;
        unique case (r_req.func)
            FUNC_CMD, FUNC_DATA: begin
                w_has_job      = 1'b1;
                w_job.rs       = (r_req.func == FUNC_DATA);
                w_job.byte_val = r_req.value;
            end
            FUNC_CURSOR: begin
                w_has_job      = w_row_ok;
                w_job.byte_val = w_addr;
            end
            FUNC_DATA_AT: begin
                if (r_step == 4'd0) begin
                    w_has_job      = w_row_ok;
                    w_final        = 1'b0;
                    w_job.byte_val = w_addr;
                end else begin
                    w_has_job      = 1'b1;
                    w_job.rs       = 1'b1;
                    w_job.byte_val = r_req.value;
                end
            end
            FUNC_POWER: begin
                w_has_job = 1'b1;
                w_final   = (r_step == INIT_LAST_STEP);
                if (r_step == 4'd0) begin
                    w_job.idle_job  = 1'b1;
                    w_job.tail_hold = i_wait_us;
                end else begin
                    w_job.byte_val  = f_init_byte(r_step, i_four_bit);
                    w_job.tail_hold = f_init_tail(r_step);
                end
            end
            default: begin
                w_has_job = 1'b0;
            end
        endcase
        w_job.last = w_final;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (w_has_job)    n_state = ST_WAIT;
                else if (w_final) n_state = ST_IDLE;
            end
            ST_WAIT: begin
                if (!i_dp_busy) n_state = w_final ? ST_IDLE : ST_ISSUE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = w_job;
        o_cmd.start = 1'b0;
        n_step      = r_step;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                n_step      = 4'd0;
            end
            ST_ISSUE: begin
                o_cmd.start = w_has_job && !i_dp_busy;
                if (!w_has_job && !w_final) n_step = r_step + 4'd1;
            end
            ST_WAIT: begin
                if (!i_dp_busy) n_step = r_step + 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) r_req <= i_req;
    end

endmodule

// ----- design/lcdseq_dp.sv -----
// Datapath of the LCD bus sequencer: turns one job into its pin states.
// Depends on lcdseq_pkg; holds the output register of the pin channel.
module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_four_bit,
    input  logic [7:0]  i_en_us,
    output logic        o_busy,
    output logic        o_pin_valid,
    input  logic        i_pin_ready,
    output t_pin        o_pin
);

    logic        r_busy;
    logic [1:0]  r_phase;
    logic        r_idle_job;
    logic        r_rs;
    logic [7:0]  r_byte;
    logic [15:0] r_tail;
    logic        r_last;
    logic        r_out_valid;
    t_pin        r_out;

    logic [1:0]  w_final_phase;
    logic        w_at_final;
    logic        w_emit;
    t_pin        w_pin;

    // In 4-bit mode phases 0 and 1 carry the high nibble, 2 and 3 the low one.
    assign w_final_phase = r_idle_job ? 2'd0 : (i_four_bit ? 2'd3 : 2'd1);
    assign w_at_final    = (r_phase == w_final_phase);
    assign w_emit        = r_busy && (!r_out_valid || i_pin_ready);

    always_comb begin
        w_pin.reg_select  = r_rs && !r_idle_job;
        if (r_idle_job)
            w_pin.data_lines = 8'h00;
        else if (i_four_bit)
            w_pin.data_lines = {4'h0, r_phase[1] ? r_byte[3:0] : r_byte[7:4]};
        else
            w_pin.data_lines = r_byte;
        w_pin.enable_line = !r_idle_job && !r_phase[0];
        if (w_pin.enable_line)
            w_pin.hold_us = {8'h00, i_en_us};
        else
            w_pin.hold_us = w_at_final ? r_tail : 16'd0;
        w_pin.last = w_at_final && r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
            end else if (w_emit) begin
                if (w_at_final) r_busy <= 1'b0;
                else            r_phase <= r_phase + 2'd1;
            end
            if (w_emit)           r_out_valid <= 1'b1;
            else if (i_pin_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idle_job <= i_cmd.idle_job;
            r_rs       <= i_cmd.rs;
            r_byte     <= i_cmd.byte_val;
            r_tail     <= i_cmd.tail_hold;
            r_last     <= i_cmd.last;
        end
        if (w_emit) r_out <= w_pin;
    end

    assign o_busy      = r_busy;
    assign o_pin_valid = r_out_valid;
    assign o_pin       = r_out;

endmodule

// ----- design/char_lcd_bus_sequencer.sv -----
// Top level of the character LCD bus sequencer: configuration registers,
// controller and datapath. Depends on lcdseq_pkg, lcdseq_ctrl and lcdseq_dp.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_req_valid / o_req_ready  i_req (t_req)
//   pin       out        o_pin_valid / i_pin_ready  o_pin (t_pin)
//   config    in         i_cfg_we (write only)      i_cfg_index, i_cfg_wdata
//
// Each pin state is registered in the datapath and leaves it when the output
// is taken; a byte is 2 pin states on an 8-bit bus and 4 on a 4-bit bus.
// Each job is handed from the controller to the datapath, and each request
// is taken while the controller is idle.
// Hold times are reported, not counted: the pin driver downstream waits them.
// Reset is synchronous; it returns the registers to their defaults and stops
// any request. A stalled output holds the datapath, and the controller with it.
module char_lcd_bus_sequencer
    import lcdseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_pin_valid,
    input  logic        i_pin_ready,
    output t_pin        o_pin,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    logic        r_four_bit;
    logic [7:0]  r_en_us;
    logic [15:0] r_wait_us;

    t_dp_cmd     w_cmd;
    logic        w_dp_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit <= 1'b0;
            r_en_us    <= EN_US_RESET;
            r_wait_us  <= WAIT_US_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOUR_BIT: r_four_bit <= i_cfg_wdata[0];
                CFG_EN_US:    r_en_us    <= i_cfg_wdata[7:0];
                CFG_WAIT_US:  r_wait_us  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    lcdseq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_four_bit  (r_four_bit),
        .i_wait_us   (r_wait_us),
        .i_dp_busy   (w_dp_busy),
        .o_cmd       (w_cmd)
    );

    lcdseq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_four_bit  (r_four_bit),
        .i_en_us     (r_en_us),
        .o_busy      (w_dp_busy),
        .o_pin_valid (o_pin_valid),
        .i_pin_ready (i_pin_ready),
        .o_pin       (o_pin)
    );

    // A new request is only taken once the datapath has finished its job.
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !w_dp_busy)
        else $error("request taken while datapath busy");

    // A job is never issued on top of one still running.
    a_start_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_dp_busy)
        else $error("job issued while datapath busy");

    // The final pin state of a request always has the enable line low.
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pin_valid && o_pin.last) |-> !o_pin.enable_line)
        else $error("last pin state with enable high");

    // On a 4-bit bus the upper data lines stay low.
    a_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pin_valid && r_four_bit) |-> (o_pin.data_lines[7:4] == 4'h0))
        else $error("upper data lines driven on 4-bit bus");

endmodule
